// ===== sv/vaar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_pkg
// types and constants shared by the axis-angle rotate block
// ----------------------------------------------------------------------------
package vaar_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = 2;

   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [34:0] Q30_ONE      = 35'sd1073741824;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic signed [32:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81
   };

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [33:0] cos_v;
      logic signed [33:0] sin_v;
   } trig_item_type;

endpackage

// ===== sv/vaar_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_front
// input capture and pipelined cordic for cosine and sine of the angle
// ----------------------------------------------------------------------------
module vaar_front #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [31:0]      req_vec_x,
   input  logic signed [31:0]      req_vec_y,
   input  logic signed [31:0]      req_vec_z,
   input  logic signed [15:0]      req_axis_x,
   input  logic signed [15:0]      req_axis_y,
   input  logic signed [15:0]      req_axis_z,
   input  logic [15:0]             req_angle,
   input  logic                    q_full,
   output logic                    q_push,
   output vaar_pkg::trig_item_type q_data
);
   import vaar_pkg::*;

   localparam int N = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

   logic               vld_ff  [0:N];
   logic signed [33:0] x_ff    [0:N];
   logic signed [33:0] y_ff    [0:N];
   logic signed [32:0] z_ff    [0:N];
   quad_type           quad_ff [0:N];
   logic signed [31:0] vx_ff   [0:N];
   logic signed [31:0] vy_ff   [0:N];
   logic signed [31:0] vz_ff   [0:N];
   logic signed [15:0] ax_ff   [0:N];
   logic signed [15:0] ay_ff   [0:N];
   logic signed [15:0] az_ff   [0:N];
   logic               en;

   assign en        = !(vld_ff[N] && q_full);
   assign req_ready = en;
   assign q_push    = en && vld_ff[N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
      end
      if (en) begin
         x_ff[0]    <= CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({3'b000, req_angle[13:0], 16'h0000});
         quad_ff[0] <= quad_type'(req_angle[15:14]);
         vx_ff[0]   <= req_vec_x;
         vy_ff[0]   <= req_vec_y;
         vz_ff[0]   <= req_vec_z;
         ax_ff[0]   <= req_axis_x;
         ay_ff[0]   <= req_axis_y;
         az_ff[0]   <= req_axis_z;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [32:0] z_in;

      always_comb begin
         if (!z_ff[k][32]) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - ATAN_TURNS[k];
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + ATAN_TURNS[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            quad_ff[k+1] <= quad_ff[k];
            vx_ff[k+1]   <= vx_ff[k];
            vy_ff[k+1]   <= vy_ff[k];
            vz_ff[k+1]   <= vz_ff[k];
            ax_ff[k+1]   <= ax_ff[k];
            ay_ff[k+1]   <= ay_ff[k];
            az_ff[k+1]   <= az_ff[k];
         end
      end
   end

   always_comb begin
      q_data.vec_x  = vx_ff[N];
      q_data.vec_y  = vy_ff[N];
      q_data.vec_z  = vz_ff[N];
      q_data.axis_x = ax_ff[N];
      q_data.axis_y = ay_ff[N];
      q_data.axis_z = az_ff[N];
      case (quad_ff[N])
         QUAD_0: begin
            q_data.cos_v = x_ff[N];
            q_data.sin_v = y_ff[N];
         end
         QUAD_1: begin
            q_data.cos_v = -y_ff[N];
            q_data.sin_v = x_ff[N];
         end
         QUAD_2: begin
            q_data.cos_v = -x_ff[N];
            q_data.sin_v = -y_ff[N];
         end
         default: begin
            q_data.cos_v = y_ff[N];
            q_data.sin_v = -x_ff[N];
         end
      endcase
   end

endmodule

// ===== sv/vaar_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_fifo
// short queue between the trig front and the matrix back
// ----------------------------------------------------------------------------
module vaar_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vaar_pkg::trig_item_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output vaar_pkg::trig_item_type pop_data
);
   import vaar_pkg::*;

   trig_item_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/vaar_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaar_back
// rotation matrix build, matrix-vector product, rounding and clipping
// ----------------------------------------------------------------------------
module vaar_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  vaar_pkg::trig_item_type q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_rot_x,
   output logic signed [31:0]      rsp_rot_y,
   output logic signed [31:0]      rsp_rot_z,
   output logic                    rsp_saturated
);
   import vaar_pkg::*;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   assign en    = !(v6_ff && !rsp_ready);
   assign q_pop = en && q_valid;

   // stage 1: axis products
   logic signed [31:0] p_ff   [6];
   logic signed [49:0] asr_ff [3];
   logic signed [34:0] cf1_ff;
   logic signed [33:0] c1_ff;
   logic signed [31:0] v1v_ff [3];
   logic signed [15:0] ax [3];
   logic signed [31:0] vin [3];

   assign ax[0]  = q_data.axis_x;
   assign ax[1]  = q_data.axis_y;
   assign ax[2]  = q_data.axis_z;
   assign vin[0] = q_data.vec_x;
   assign vin[1] = q_data.vec_y;
   assign vin[2] = q_data.vec_z;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= ax[0] * ax[0];
         p_ff[1] <= ax[0] * ax[1];
         p_ff[2] <= ax[0] * ax[2];
         p_ff[3] <= ax[1] * ax[1];
         p_ff[4] <= ax[1] * ax[2];
         p_ff[5] <= ax[2] * ax[2];
         for (int i = 0; i < 3; i++) begin
            asr_ff[i] <= ax[i] * q_data.sin_v;
            v1v_ff[i] <= vin[i];
         end
         cf1_ff <= Q30_ONE - 35'(q_data.cos_v);
         c1_ff  <= q_data.cos_v;
      end
   end

   // stage 2: rounded coefficients
   logic signed [35:0] aa_ff  [6];
   logic signed [35:0] as_ff  [3];
   logic signed [33:0] c2_ff;
   logic signed [31:0] v2v_ff [3];
   logic signed [66:0] aa_prod [6];
   logic signed [66:0] aa_rnd  [6];
   logic signed [49:0] as_rnd  [3];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         aa_prod[i] = p_ff[i] * cf1_ff;
         aa_rnd[i]  = (aa_prod[i] + 67'sd134217728) >>> 28;
      end
      for (int i = 0; i < 3; i++) begin
         as_rnd[i] = (asr_ff[i] + 50'sd8192) >>> 14;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            aa_ff[i] <= aa_rnd[i][35:0];
         end
         for (int i = 0; i < 3; i++) begin
            as_ff[i]  <= as_rnd[i][35:0];
            v2v_ff[i] <= v1v_ff[i];
         end
         c2_ff <= c1_ff;
      end
   end

   // stage 3: matrix entries
   logic signed [36:0] m_ff   [3][3];
   logic signed [31:0] v3v_ff [3];
   logic signed [36:0] c37;

   assign c37 = 37'(c2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0][0] <= 37'(aa_ff[0]) + c37;
         m_ff[0][1] <= 37'(aa_ff[1]) - 37'(as_ff[2]);
         m_ff[0][2] <= 37'(aa_ff[2]) + 37'(as_ff[1]);
         m_ff[1][0] <= 37'(aa_ff[1]) + 37'(as_ff[2]);
         m_ff[1][1] <= 37'(aa_ff[3]) + c37;
         m_ff[1][2] <= 37'(aa_ff[4]) - 37'(as_ff[0]);
         m_ff[2][0] <= 37'(aa_ff[2]) - 37'(as_ff[1]);
         m_ff[2][1] <= 37'(aa_ff[4]) + 37'(as_ff[0]);
         m_ff[2][2] <= 37'(aa_ff[5]) + c37;
         for (int i = 0; i < 3; i++) begin
            v3v_ff[i] <= v2v_ff[i];
         end
      end
   end

   // stage 4: split products
   logic signed [52:0] hp_ff [3][3];
   logic signed [53:0] lp_ff [3][3];
   logic signed [15:0] vhi [3];
   logic signed [16:0] vlo [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vhi[k] = v3v_ff[k][31:16];
         vlo[k] = $signed({1'b0, v3v_ff[k][15:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               hp_ff[i][k] <= m_ff[i][k] * vhi[k];
               lp_ff[i][k] <= m_ff[i][k] * vlo[k];
            end
         end
      end
   end

   // stage 5: sums
   logic signed [54:0] hs_ff [3];
   logic signed [55:0] ls_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            hs_ff[i] <= 55'(hp_ff[i][0]) + 55'(hp_ff[i][1]) + 55'(hp_ff[i][2]);
            ls_ff[i] <= 56'(lp_ff[i][0]) + 56'(lp_ff[i][1]) + 56'(lp_ff[i][2]);
         end
      end
   end

   // stage 6: round and clip
   logic signed [55:0] lt    [3];
   logic signed [55:0] tot   [3];
   logic signed [55:0] rr    [3];
   logic signed [31:0] clip  [3];
   logic [2:0]         sat;
   logic signed [31:0] rot_ff [3];
   logic               sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lt[i]  = (ls_ff[i] + 56'sd536870912) >>> 16;
         tot[i] = 56'(hs_ff[i]) + lt[i];
         rr[i]  = tot[i] >>> 14;
         if (rr[i] > 56'sd2147483647) begin
            clip[i] = 32'sh7FFFFFFF;
            sat[i]  = 1'b1;
         end else if (rr[i] < -56'sd2147483648) begin
            clip[i] = 32'sh80000000;
            sat[i]  = 1'b1;
         end else begin
            clip[i] = rr[i][31:0];
            sat[i]  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rot_ff[i] <= clip[i];
         end
         sat_ff <= |sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   assign rsp_valid     = v6_ff;
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ===== sv/vector_axis_angle_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_axis_angle_rotate
// rotates a q16.16 vector about a unit axis by a binary angle
//
//   channel   direction   fields
//   req_      in          vec_x/y/z, axis_x/y/z, angle
//   rsp_      out         rot_x/y/z, saturated
//
// one item per cycle sustained while rsp_ready stays high; an item passes through
// capture, one cordic stage per iteration, queue, six back stages
// the front stalls only when the four-entry queue is full
// the back stalls when its output register holds an item not yet taken
// synchronous reset clears valids and queue pointers
// ----------------------------------------------------------------------------
module vector_axis_angle_rotate #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic [15:0]        req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z,
   output logic               rsp_saturated
);
   import vaar_pkg::*;

   trig_item_type push_data, pop_data;
   logic          push, full, pop, not_empty;

   vaar_front #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .req_angle  (req_angle),
      .q_full     (full),
      .q_push     (push),
      .q_data     (push_data)
   );

   vaar_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   vaar_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (not_empty),
      .q_data        (pop_data),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rot_x     (rsp_rot_x),
      .rsp_rot_y     (rsp_rot_y),
      .rsp_rot_z     (rsp_rot_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== verif/tb_vector_axis_angle_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_axis_angle_rotate
// self-checking bench for the axis-angle rotate block
//
// a bit-exact predictor (cordic sine/cosine, rotation matrix, rounding and
// clipping) computes each expected result when its item is accepted; a small
// scoreboard compares results in order. directed corner items come first,
// then random items with random gaps on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb_vector_axis_angle_rotate;

   localparam int TRIG_ITERATIONS = 16;
   localparam int N_RANDOM        = 930;

   localparam longint ATAN_TBL [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };
   localparam longint ROT_MAX = 64'sd2147483647;
   localparam longint ROT_MIN = -64'sd2147483648;
   localparam longint ONE_Q30 = 64'sd1073741824;

   typedef struct {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic               saturated;
   } rotated_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_vec_x;
   logic signed [31:0] req_vec_y;
   logic signed [31:0] req_vec_z;
   logic signed [15:0] req_axis_x;
   logic signed [15:0] req_axis_y;
   logic signed [15:0] req_axis_z;
   logic [15:0]        req_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_rot_x;
   logic signed [31:0] rsp_rot_y;
   logic signed [31:0] rsp_rot_z;
   logic               rsp_saturated;

   int  n_accepted;
   int  n_sat;
   bit  no_idle;

   vector_axis_angle_rotate #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rotated_type rotate_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                                                 logic signed [31:0] vz, logic signed [15:0] ax,
                                                 logic signed [15:0] ay, logic signed [15:0] az,
                                                 logic [15:0] ang);
      longint      v [3];
      longint      a [3];
      longint      as [3];
      longint      aa [3][3];
      longint      m [3][3];
      longint      x, y, z, nx, c, s, cf, hi, lo, r;
      rotated_type res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      a[0] = ax; a[1] = ay; a[2] = az;
      z = longint'(ang[13:0]) * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TBL[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TBL[i];
         end
         x = nx;
      end
      case (ang[15:14])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      cf = ONE_Q30 - c;
      for (int i = 0; i < 3; i++) begin
         as[i] = (a[i] * s + 8192) >>> 14;
         for (int j = 0; j < 3; j++)
            aa[i][j] = (a[i] * a[j] * cf + (64'sd1 << 27)) >>> 28;
      end
      m[0][0] = aa[0][0] + c;     m[0][1] = aa[0][1] - as[2]; m[0][2] = aa[0][2] + as[1];
      m[1][0] = aa[0][1] + as[2]; m[1][1] = aa[1][1] + c;     m[1][2] = aa[1][2] - as[0];
      m[2][0] = aa[0][2] - as[1]; m[2][1] = aa[1][2] + as[0]; m[2][2] = aa[2][2] + c;
      res.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         hi = 0;
         lo = 0;
         for (int k = 0; k < 3; k++) begin
            hi += m[i][k] * (v[k] >>> 16);
            lo += m[i][k] * (v[k] & 64'hFFFF);
         end
         r = (hi + ((lo + (64'sd1 << 29)) >>> 16)) >>> 14;
         if (r > ROT_MAX) begin
            r = ROT_MAX;
            res.saturated = 1'b1;
         end else if (r < ROT_MIN) begin
            r = ROT_MIN;
            res.saturated = 1'b1;
         end
         case (i)
            0: res.rot_x = r[31:0];
            1: res.rot_y = r[31:0];
            default: res.rot_z = r[31:0];
         endcase
      end
      return res;
   endfunction

   class rotate_scoreboard;
      rotated_type pending_q [$];
      int          n_errors;
      int          n_checked;

      function void note_item(rotated_type exp_res);
         pending_q.push_back(exp_res);
      endfunction

      task report(string what, longint got, longint want);
         $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
         n_errors++;
      endtask

      task check_result(rotated_type got);
         rotated_type want;
         if (pending_q.size() == 0) begin
            report("unexpected item", 0, 0);
            return;
         end
         want = pending_q.pop_front();
         n_checked++;
         if (got.rot_x !== want.rot_x) report("rot_x", got.rot_x, want.rot_x);
         if (got.rot_y !== want.rot_y) report("rot_y", got.rot_y, want.rot_y);
         if (got.rot_z !== want.rot_z) report("rot_z", got.rot_z, want.rot_z);
         if (got.saturated !== want.saturated)
            report("saturated", got.saturated, want.saturated);
      endtask
   endclass

   rotate_scoreboard sb = new();

   // monitor
   always @(posedge clock) begin
      rotated_type got;
      rotated_type exp_res;
      if (!reset) begin
         if (req_valid && req_ready) begin
            exp_res = rotate_vector(req_vec_x, req_vec_y, req_vec_z, req_axis_x,
                                    req_axis_y, req_axis_z, req_angle);
            if (exp_res.saturated) n_sat++;
            sb.note_item(exp_res);
            n_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got.rot_x     = rsp_rot_x;
            got.rot_y     = rsp_rot_y;
            got.rot_z     = rsp_rot_z;
            got.saturated = rsp_saturated;
            sb.check_result(got);
         end
      end
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task send_item(logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vz,
                  logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
                  logic [15:0] ang);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      req_axis_x <= ax;
      req_axis_y <= ay;
      req_axis_z <= az;
      req_angle  <= ang;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'sd11585;
         4: return -16'sd9459;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_component();
      case ($urandom_range(0, 3))
         0: return 32'($urandom());
         1: return 32'($signed(16'($urandom_range(0, 65535)))) <<< $urandom_range(0, 16);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed(24'($urandom())));
      endcase
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int p;
      bit held;
      rsp_ready <= 1'b0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && n_accepted >= 300) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         p = $urandom_range(0, 99);
         if (no_idle || p < 70) begin
            rsp_ready <= 1'b1;
         end else if (p < 95) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(8, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      logic signed [31:0] big;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_vec_x  <= '0;
      req_vec_y  <= '0;
      req_vec_z  <= '0;
      req_axis_x <= '0;
      req_axis_y <= '0;
      req_axis_z <= '0;
      req_angle  <= '0;
      no_idle     = 1'b0;
      n_accepted  = 0;
      n_sat       = 0;
      big         = 32'h7FFF_FFFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: quadrants, axes, extremes, non-unit axes, clipping
      send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'sd0, 16'sd0, 16'sd16384, 16'd0);
      send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'sd0, 16'sd0, 16'sd16384,
                16'd16384);
      send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'sd16384, 16'sd0, 16'sd0,
                16'd32768);
      send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'sd0, 16'sd16384, 16'sd0,
                16'd49152);
      send_item(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000, 16'sd0, -16'sd16384, 16'sd0,
                16'd65535);
      send_item(32'sh0005_8000, 32'sh0000_0001, -32'sd1, 16'sd9459, 16'sd9459, 16'sd9459,
                16'd8192);
      send_item(32'sh0005_8000, 32'sh0000_0001, -32'sd1, 16'sd9459, 16'sd9459, 16'sd9459,
                16'd16383);
      send_item(big, big, big, 16'sd0, 16'sd0, 16'sd16384, 16'd8192);
      send_item(~big, ~big, ~big, 16'sd0, 16'sd0, 16'sd16384, 16'd8192);
      send_item(big, ~big, big, 16'sd16384, 16'sd0, 16'sd0, 16'd0);
      send_item(big, big, big, -16'sd32768, -16'sd32768, -16'sd32768, 16'd32768);
      send_item(~big, big, 32'sd0, 16'sd32767, -16'sd32768, 16'sd32767, 16'd40000);
      send_item(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, 16'sd8192, 16'sd0, 16'sd0,
                16'd16384);
      send_item(32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, 16'sd0, 16'sd0, 16'sd0,
                16'd12345);
      send_item(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd16384, 16'sd16384, 16'd1);
      send_item(32'sd1, -32'sd1, 32'sd32768, 16'sd11585, 16'sd11585, 16'sd0, 16'd24576);
      send_item(big, big, big, 16'sd11585, -16'sd11585, 16'sd0, 16'd57344);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'sh5555, 16'shAAAA, 16'sh7FFF,
                16'hAAAA);
      send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 16'shAAAA, 16'sh5555, -16'sd1,
                16'h5555);

      // random
      for (int n = 0; n < N_RANDOM; n++) begin
         no_idle = (n >= 500 && n < 600);
         send_item(pick_component(), pick_component(), pick_component(), pick_axis(),
                   pick_axis(), pick_axis(), 16'($urandom_range(0, 65535)));
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (TRIG_ITERATIONS + 40) @(posedge clock);
      $display("items accepted %0d, results checked %0d, saturated %0d, errors %0d",
               n_accepted, sb.n_checked, n_sat, sb.n_errors);
      $display("covered quadrant edges, extreme fields, non-unit axes, clipping, long output stall");
      if (sb.n_errors == 0 && sb.pending_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout");
      $display("FAIL");
      $finish;
   end

endmodule
